@@ hw/rtl/sqmf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqmf_pkg
// Shared types, sizes and the control store of the square max filter.
// ----------------------------------------------------------------------------
package sqmf_pkg;

	localparam int MAX_ROWS   = 64;
	localparam int MAX_COLS   = 64;
	localparam int MAX_RADIUS = 7;

	localparam int ROW_W  = 6;
	localparam int COL_W  = 6;
	localparam int VAL_W  = 16;
	localparam int RAD_W  = 3;
	localparam int SIZE_W = 7;
	localparam int ADDR_W = ROW_W + COL_W;
	localparam int DEPTH  = MAX_ROWS * MAX_COLS;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_ROWS = 2'd0,
		REG_GRID_COLS = 2'd1,
		REG_RADIUS    = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef logic [2:0] step_t;

	localparam step_t STEP_WAIT   = 3'd0;
	localparam step_t STEP_DECODE = 3'd1;
	localparam step_t STEP_SETUP  = 3'd2;
	localparam step_t STEP_SCAN   = 3'd3;
	localparam step_t STEP_DRAIN  = 3'd4;
	localparam step_t STEP_EMIT   = 3'd5;

	typedef enum logic [2:0] {
		COND_JMP       = 3'd0,
		COND_WAIT_IN   = 3'd1,
		COND_BR_WRITE  = 3'd2,
		COND_BR_ERR    = 3'd3,
		COND_WAIT_SCAN = 3'd4,
		COND_WAIT_OUT  = 3'd5
	} cond_t;

	typedef struct packed {
		logic  take_in;
		logic  decode;
		logic  setup;
		logic  scan;
		logic  emit;
		cond_t cond;
		step_t target;
	} ctrl_word_t;

	typedef struct packed {
		logic in_accept;
		logic write_ok;
		logic err;
		logic scan_last;
		logic out_free;
	} seq_flags_t;

	function automatic ctrl_word_t ucode_rom(input step_t step);
		ctrl_word_t cw;
		cw = '{take_in: 1'b0, decode: 1'b0, setup: 1'b0, scan: 1'b0, emit: 1'b0,
			cond: COND_JMP, target: STEP_WAIT};
		unique case (step)
			STEP_WAIT: begin
				cw.take_in = 1'b1;
				cw.cond    = COND_WAIT_IN;
				cw.target  = STEP_DECODE;
			end
			STEP_DECODE: begin
				cw.decode = 1'b1;
				cw.cond   = COND_BR_WRITE;
				cw.target = STEP_WAIT;
			end
			STEP_SETUP: begin
				cw.setup  = 1'b1;
				cw.cond   = COND_BR_ERR;
				cw.target = STEP_EMIT;
			end
			STEP_SCAN: begin
				cw.scan   = 1'b1;
				cw.cond   = COND_WAIT_SCAN;
				cw.target = STEP_DRAIN;
			end
			STEP_DRAIN: begin
				cw.cond   = COND_JMP;
				cw.target = STEP_EMIT;
			end
			STEP_EMIT: begin
				cw.emit   = 1'b1;
				cw.cond   = COND_WAIT_OUT;
				cw.target = STEP_WAIT;
			end
			default: begin
				cw.cond   = COND_JMP;
				cw.target = STEP_WAIT;
			end
		endcase
		return cw;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/sqmf_useq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqmf_useq
// Step counter over the control store, with conditional jumps on datapath flags.
// ----------------------------------------------------------------------------
module sqmf_useq
	import sqmf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire seq_flags_t flags,
	output ctrl_word_t      cw
);

	step_t step_q;
	step_t step_next;
	step_t step_inc;

	assign cw       = ucode_rom(step_q);
	assign step_inc = step_q + step_t'(1);

	always_comb begin
		unique case (cw.cond)
			COND_JMP:       step_next = cw.target;
			COND_WAIT_IN:   step_next = flags.in_accept ? cw.target : step_q;
			COND_BR_WRITE:  step_next = (flags.write_ok || flags.err) ?
				(flags.write_ok ? cw.target : step_inc) : step_inc;
			COND_BR_ERR:    step_next = flags.err ? cw.target : step_inc;
			COND_WAIT_SCAN: step_next = flags.scan_last ? cw.target : step_q;
			COND_WAIT_OUT:  step_next = flags.out_free ? cw.target : step_q;
			default:        step_next = STEP_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_WAIT;
		end else begin
			step_q <= step_next;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/square_max_filter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// square_max_filter
// Grid store with clipped square-window maximum queries.
// ----------------------------------------------------------------------------
// operation: a write is stored in the decode step; a query reads every cell of the
//   clipped window, one grid read per cycle, and registers its maximum at the output
// throughput: one transaction at a time; next input taken while a result waits
// reset: grid size 64 x 64, radius 1; cell contents undefined until written
// ----------------------------------------------------------------------------
module square_max_filter
	import sqmf_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // row, col, value, zero pad
	input  wire logic                  s_axis_tuser,   // op
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // window_max
	output logic                       m_axis_tuser,   // out_of_range
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [SIZE_W-1:0] grid_rows_q;
	logic [SIZE_W-1:0] grid_cols_q;
	logic [RAD_W-1:0]  radius_q;

	op_t              op_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [VAL_W-1:0] value_q;

	logic [ROW_W-1:0] i_q, r1_q;
	logic [COL_W-1:0] j_q, c0_q, c1_q;
	logic [VAL_W-1:0] rd_q;
	logic             cmp_s1;
	logic [VAL_W-1:0] best_q;

	logic             out_valid_q;
	logic [VAL_W-1:0] out_max_q;
	logic             out_err_q;

	logic [VAL_W-1:0] mem [DEPTH];

	ctrl_word_t cw;
	seq_flags_t flags;

	logic [SIZE_W-1:0] rows_eff, cols_eff;
	logic [SIZE_W-1:0] r_sum, c_sum;
	logic [ROW_W-1:0]  r0, r1;
	logic [COL_W-1:0]  c0, c1;
	logic              in_accept, err, out_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= SIZE_W'(MAX_ROWS);
			grid_cols_q <= SIZE_W'(MAX_COLS);
			radius_q    <= RAD_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GRID_ROWS: grid_rows_q <= cfg_data;
				REG_GRID_COLS: grid_cols_q <= cfg_data;
				REG_RADIUS:    radius_q    <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	// effective grid size
	always_comb begin
		if (grid_rows_q == '0) rows_eff = SIZE_W'(1);
		else if (grid_rows_q > SIZE_W'(MAX_ROWS)) rows_eff = SIZE_W'(MAX_ROWS);
		else rows_eff = grid_rows_q;
		if (grid_cols_q == '0) cols_eff = SIZE_W'(1);
		else if (grid_cols_q > SIZE_W'(MAX_COLS)) cols_eff = SIZE_W'(MAX_COLS);
		else cols_eff = grid_cols_q;
	end

	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = cw.take_in;

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q    <= op_t'(s_axis_tuser);
			row_q   <= s_axis_tdata[ROW_W-1:0];
			col_q   <= s_axis_tdata[ROW_W+COL_W-1:ROW_W];
			value_q <= s_axis_tdata[ROW_W+COL_W+VAL_W-1:ROW_W+COL_W];
		end
	end

	assign err = !(({1'b0, row_q} < rows_eff) && ({1'b0, col_q} < cols_eff));

	// clipped window bounds
	assign r_sum = {1'b0, row_q} + SIZE_W'(radius_q);
	assign c_sum = {1'b0, col_q} + SIZE_W'(radius_q);
	assign r0 = (row_q > ROW_W'(radius_q)) ? row_q - ROW_W'(radius_q) : '0;
	assign c0 = (col_q > COL_W'(radius_q)) ? col_q - COL_W'(radius_q) : '0;
	assign r1 = (r_sum < rows_eff) ? r_sum[ROW_W-1:0] : ROW_W'(rows_eff - SIZE_W'(1));
	assign c1 = (c_sum < cols_eff) ? c_sum[COL_W-1:0] : COL_W'(cols_eff - SIZE_W'(1));

	always_ff @(posedge clk) begin
		if (cw.setup) begin
			i_q  <= r0;
			j_q  <= c0;
			c0_q <= c0;
			r1_q <= r1;
			c1_q <= c1;
		end else if (cw.scan) begin
			if (j_q == c1_q) begin
				j_q <= c0_q;
				i_q <= i_q + ROW_W'(1);
			end else begin
				j_q <= j_q + COL_W'(1);
			end
		end
	end

	// grid store
	always_ff @(posedge clk) begin
		if (cw.decode && flags.write_ok) begin
			mem[{row_q, col_q}] <= value_q;
		end
		if (cw.scan) begin
			rd_q <= mem[{i_q, j_q}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_s1 <= 1'b0;
		end else begin
			cmp_s1 <= cw.scan;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.setup) begin
			best_q <= '0;
		end else if (cmp_s1 && (rd_q > best_q)) begin
			best_q <= rd_q;
		end
	end

	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cw.emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.emit && out_free) begin
			out_max_q <= err ? '0 : best_q;
			out_err_q <= err;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_max_q;
	assign m_axis_tuser  = out_err_q;

	assign flags.in_accept = in_accept;
	assign flags.write_ok  = (op_q == OP_WRITE) && !err;
	assign flags.err       = err;
	assign flags.scan_last = (i_q == r1_q) && (j_q == c1_q);
	assign flags.out_free  = out_free;

	sqmf_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.cw     (cw)
	);

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for square_max_filter. Writes grid cells and queries
// clipped square-window maxima under several grid sizes and radii, predicts
// every result from its own copy of the grid and compares field by field.
// ----------------------------------------------------------------------------
module tb;
	import sqmf_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 5;
	localparam int RANDOM_ITEMS = 1500;
	localparam int PHASE_ITEMS  = 200;
	localparam int WRITE_SETTLE = 16;
	localparam int TAIL_CYCLES  = 250;
	localparam int STALL_LIMIT  = 4000;
	localparam int MAX_GAP      = 5;
	localparam int SIZE_MAX     = (1 << SIZE_W) - 1;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [VAL_W-1:0] peak;
		logic             off_grid;
	} window_result_t;

	class dilation_tracker;
		logic [VAL_W-1:0]    cells [DEPTH];
		logic [SIZE_W-1:0]   rows_reg;
		logic [SIZE_W-1:0]   cols_reg;
		logic [RAD_W-1:0]    rad_reg;
		window_result_t      pending_peaks [$];
		int                  errors;
		int                  results;

		function new();
			rows_reg = SIZE_W'(MAX_ROWS);
			cols_reg = SIZE_W'(MAX_COLS);
			rad_reg  = RAD_W'(1);
			errors   = 0;
			results  = 0;
		endfunction

		function void set_register(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] d);
			case (idx)
				REG_GRID_ROWS: rows_reg = d[SIZE_W-1:0];
				REG_GRID_COLS: cols_reg = d[SIZE_W-1:0];
				REG_RADIUS:    rad_reg  = d[RAD_W-1:0];
				default: ;
			endcase
		endfunction

		function int used_rows();
			if (rows_reg == 0) return 1;
			if (rows_reg > MAX_ROWS) return MAX_ROWS;
			return int'(rows_reg);
		endfunction

		function int used_cols();
			if (cols_reg == 0) return 1;
			if (cols_reg > MAX_COLS) return MAX_COLS;
			return int'(cols_reg);
		endfunction

		function int used_radius();
			return (rad_reg > MAX_RADIUS) ? MAX_RADIUS : int'(rad_reg);
		endfunction

		function bit holds(input int r, input int c);
			return (r < used_rows()) && (c < used_cols());
		endfunction

		function void window_bounds(input int r, input int c, output int r0,
				output int r1, output int c0, output int c1);
			int rad;
			rad = used_radius();
			r0 = (r > rad) ? r - rad : 0;
			r1 = (r + rad < used_rows()) ? r + rad : used_rows() - 1;
			c0 = (c > rad) ? c - rad : 0;
			c1 = (c + rad < used_cols()) ? c + rad : used_cols() - 1;
		endfunction

		function logic [VAL_W-1:0] window_peak(input int r, input int c);
			int r0, r1, c0, c1;
			logic [VAL_W-1:0] best;
			best = '0;
			window_bounds(r, c, r0, r1, c0, c1);
			for (int i = r0; i <= r1; i++)
				for (int j = c0; j <= c1; j++)
					if (cells[i * MAX_COLS + j] > best) best = cells[i * MAX_COLS + j];
			return best;
		endfunction

		function void take_item(input op_t op, input int r, input int c,
				input logic [VAL_W-1:0] v);
			window_result_t want;
			if (!holds(r, c)) begin
				want.peak     = '0;
				want.off_grid = 1'b1;
				pending_peaks.insert(pending_peaks.size(), want);
			end else if (op == OP_WRITE) begin
				cells[r * MAX_COLS + c] = v;
			end else begin
				want.peak     = window_peak(r, c);
				want.off_grid = 1'b0;
				pending_peaks.insert(pending_peaks.size(), want);
			end
		endfunction

		function void match_result(input logic [VAL_W-1:0] peak, input logic off_grid);
			window_result_t want;
			results++;
			if (pending_peaks.size() == 0) begin
				errors++;
				$error("unexpected result: window_max %h out_of_range %b", peak, off_grid);
				return;
			end
			want = pending_peaks[0];
			pending_peaks.delete(0);
			if (peak !== want.peak) begin
				errors++;
				$error("window_max: expected %h, got %h", want.peak, peak);
			end
			if (off_grid !== want.off_grid) begin
				errors++;
				$error("out_of_range: expected %b, got %b", want.off_grid, off_grid);
			end
		endfunction

		function int outstanding();
			return pending_peaks.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;   // row, col, value, zero pad
	logic                  s_axis_tuser;   // op
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;   // window_max
	logic                  m_axis_tuser;   // out_of_range
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	dilation_tracker tracker;
	bit              written [DEPTH];
	bit              quiet;
	int              sent;
	int              queries_sent;
	int              off_grid_sent;
	int              settings;
	int              stall_cycles = 0;

	int fixed_rows [5] = '{MAX_ROWS, 1, MAX_ROWS, 1, 100};
	int fixed_cols [5] = '{MAX_COLS, MAX_COLS, 1, 1, 0};
	int fixed_rad  [5] = '{MAX_RADIUS, 3, 2, 0, 4};

	square_max_filter uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	function automatic int pick_gap();
		return quiet ? 0 : int'($urandom_range(0, MAX_GAP));
	endfunction

	function automatic logic [VAL_W-1:0] rand_value();
		return VAL_W'($urandom) >> $urandom_range(0, VAL_W - 1);
	endfunction

	function automatic int pick_size();
		if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, SIZE_MAX));
		return int'($urandom_range(1, MAX_ROWS));
	endfunction

	task automatic send_cell(input op_t op, input int r, input int c,
			input logic [VAL_W-1:0] v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= IN_DATA_W'({v, COL_W'(c), ROW_W'(r)});
		do @(posedge clk); while (!s_axis_tready);
		if (!tracker.holds(r, c)) off_grid_sent++;
		else if (op == OP_WRITE) written[r * MAX_COLS + c] = 1'b1;
		if (op == OP_QUERY) queries_sent++;
		tracker.take_item(op, r, c, v);
		sent++;
	endtask

	// fill whatever the window still lacks, then ask for its maximum
	task automatic probe(input int r, input int c);
		int r0, r1, c0, c1;
		tracker.window_bounds(r, c, r0, r1, c0, c1);
		for (int i = r0; i <= r1; i++)
			for (int j = c0; j <= c1; j++)
				if (!written[i * MAX_COLS + j]) send_cell(OP_WRITE, i, j, rand_value());
		send_cell(OP_QUERY, r, c, rand_value());
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(d);
		do @(posedge clk); while (!cfg_ready);
		tracker.set_register(idx, CFG_DATA_W'(d));
	endtask

	task automatic set_grid(input int rows, input int cols, input int rad, input bit spare);
		write_reg(REG_GRID_ROWS, rows);
		write_reg(REG_GRID_COLS, cols);
		write_reg(REG_RADIUS, rad);
		if (spare) write_reg(REG_SPARE, int'($urandom_range(0, SIZE_MAX)));
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// hold off until every result is back and trailing writes have landed
	task automatic quiesce();
		s_axis_tvalid <= 1'b0;
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (WRITE_SETTLE) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.match_result(m_axis_tdata, m_axis_tuser);
	end

	initial begin
		int gap;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int rand_start, phase, phase_end, pick, r, c, near_r, near_c;
		op_t op;
		tracker       = new();
		quiet         = 1'b0;
		sent          = 0;
		queries_sent  = 0;
		off_grid_sent = 0;
		settings      = 0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= OP_WRITE;
		cfg_valid     <= 1'b0;
		cfg_index     <= REG_GRID_ROWS;
		cfg_data      <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: corner clipping, extreme values
		send_cell(OP_WRITE, 0, 0, 16'hFFFF);
		send_cell(OP_WRITE, 0, 1, 16'h0000);
		send_cell(OP_WRITE, 1, 0, 16'h0001);
		send_cell(OP_WRITE, 1, 1, 16'h8000);
		send_cell(OP_QUERY, 0, 0, 16'h0000);
		send_cell(OP_WRITE, MAX_ROWS - 2, MAX_COLS - 2, 16'h0000);
		send_cell(OP_WRITE, MAX_ROWS - 2, MAX_COLS - 1, 16'h0000);
		send_cell(OP_WRITE, MAX_ROWS - 1, MAX_COLS - 2, 16'h0000);
		send_cell(OP_WRITE, MAX_ROWS - 1, MAX_COLS - 1, 16'h0000);
		send_cell(OP_QUERY, MAX_ROWS - 1, MAX_COLS - 1, 16'hFFFF);
		quiesce();

		// saturated grid sizes, radius zero, unused register index
		set_grid(0, SIZE_MAX, 0, 1'b1);
		send_cell(OP_QUERY, 0, 0, 16'h5A5A);
		send_cell(OP_QUERY, 0, 1, 16'hA5A5);
		send_cell(OP_QUERY, 1, 0, 16'h0000);
		send_cell(OP_WRITE, 1, 5, 16'h1234);
		quiesce();

		// window wider than the whole grid, off-grid by column and by row
		set_grid(3, 2, MAX_RADIUS, 1'b0);
		send_cell(OP_WRITE, 2, 0, 16'h7FFF);
		send_cell(OP_WRITE, 2, 1, 16'hFFFE);
		send_cell(OP_QUERY, 2, 1, 16'h0000);
		send_cell(OP_QUERY, 0, 2, 16'h0000);
		send_cell(OP_WRITE, 3, 0, 16'hFFFF);

		rand_start = sent;
		phase = 0;
		while (sent - rand_start < RANDOM_ITEMS) begin
			quiesce();
			if (phase < 5)
				set_grid(fixed_rows[phase], fixed_cols[phase], fixed_rad[phase], 1'b0);
			else
				set_grid(pick_size(), pick_size(), int'($urandom_range(0, MAX_RADIUS)),
					bit'($urandom_range(0, 1)));
			quiet     = (phase % 3 == 2);
			phase_end = sent + PHASE_ITEMS;
			near_r    = 0;
			near_c    = 0;
			while (sent < phase_end && sent - rand_start < RANDOM_ITEMS) begin
				pick = int'($urandom_range(0, 99));
				if (pick < 55) begin
					if ($urandom_range(0, 1) == 1) begin
						near_r = near_r + int'($urandom_range(0, 4)) - 2;
						near_c = near_c + int'($urandom_range(0, 4)) - 2;
					end else begin
						near_r = int'($urandom_range(0, tracker.used_rows() - 1));
						near_c = int'($urandom_range(0, tracker.used_cols() - 1));
					end
					if (near_r < 0) near_r = 0;
					if (near_c < 0) near_c = 0;
					if (near_r >= tracker.used_rows()) near_r = tracker.used_rows() - 1;
					if (near_c >= tracker.used_cols()) near_c = tracker.used_cols() - 1;
					probe(near_r, near_c);
				end else if (pick < 80) begin
					send_cell(OP_WRITE, int'($urandom_range(0, tracker.used_rows() - 1)),
						int'($urandom_range(0, tracker.used_cols() - 1)), rand_value());
				end else begin
					r  = int'($urandom_range(0, MAX_ROWS - 1));
					c  = int'($urandom_range(0, MAX_COLS - 1));
					op = op_t'($urandom_range(0, 1));
					if (op == OP_QUERY && tracker.holds(r, c)) probe(r, c);
					else send_cell(op, r, c, rand_value());
				end
			end
			phase++;
		end

		quiesce();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d transactions sent (%0d queries, %0d off the grid), %0d results checked",
			sent, queries_sent, off_grid_sent, tracker.results);
		$display("%0d register settings over grids up to %0dx%0d and radius 0 to %0d",
			settings, MAX_ROWS, MAX_COLS, MAX_RADIUS);
		if (tracker.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
